### rtl/core/dstwr_pkg.sv
// Shared types and constants for the two-way ranging distance pipeline.
package dstwr_pkg;

    localparam int STAMP_BITS_DEF = 32;
    localparam int MM_BITS = 24;
    localparam logic [MM_BITS-1:0] MM_RESET = 24'd307386;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NEG     = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef struct packed {
        logic [31:0] poll_sent;
        logic [31:0] reply_heard;
        logic [31:0] final_sent;
        logic [31:0] poll_heard;
        logic [31:0] reply_sent;
        logic [31:0] final_heard;
    } in_t;

    typedef struct packed {
        logic signed [32:0] flight_ticks;
        logic [31:0]        distance_mm;
        logic [1:0]         status;
    } out_t;

    // Flags that ride along with each exchange.
    typedef struct packed {
        logic zero;
        logic neg;
    } flags_t;

endpackage

### rtl/core/dstwr_front.sv
// Intervals, their sum, split products, and magnitude and sign of the difference of the two products.
module dstwr_front #(
    parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  dstwr_pkg::in_t            in_data,
    output logic                      mag_valid,
    output logic [2*STAMP_BITS-1:0]   mag,
    output logic [STAMP_BITS+1:0]     den,
    output dstwr_pkg::flags_t         flags
);
    import dstwr_pkg::*;

    localparam int SB = STAMP_BITS;
    localparam int H  = (SB + 1) / 2;
    localparam int PW = 4 * H;
    localparam int DW = SB + 2;

    logic [SB-1:0] t_ps, t_rh, t_fs, t_ph, t_rs, t_fh;

    // stage 1
    logic          v1_reg;
    logic [SB-1:0] ra_reg, da_reg, rb_reg, db_reg;
    logic [DW-1:0] den1_reg;
    // stage 2
    logic          v2_reg;
    logic [2*H-1:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic [2*H-1:0] qll_reg, qlh_reg, qhl_reg, qhh_reg;
    logic [DW-1:0] den2_reg;
    // stage 3
    logic            v3_reg;
    logic [2*SB-1:0] p_reg, q_reg;
    logic [DW-1:0]   den3_reg;
    // stage 4
    logic            v4_reg;
    logic [2*SB-1:0] mag_reg;
    logic [DW-1:0]   den4_reg;
    flags_t          flags_reg;

    logic [2*H-1:0] ra_x, rb_x, da_x, db_x;
    logic [PW-1:0]  p_next, q_next;

    assign t_ps = SB'(in_data.poll_sent);
    assign t_rh = SB'(in_data.reply_heard);
    assign t_fs = SB'(in_data.final_sent);
    assign t_ph = SB'(in_data.poll_heard);
    assign t_rs = SB'(in_data.reply_sent);
    assign t_fh = SB'(in_data.final_heard);

    assign ra_x = (2*H)'(ra_reg);
    assign rb_x = (2*H)'(rb_reg);
    assign da_x = (2*H)'(da_reg);
    assign db_x = (2*H)'(db_reg);

    assign p_next = PW'(pll_reg) + (PW'(plh_reg) << H) + (PW'(phl_reg) << H)
                  + (PW'(phh_reg) << (2*H));
    assign q_next = PW'(qll_reg) + (PW'(qlh_reg) << H) + (PW'(qhl_reg) << H)
                  + (PW'(qhh_reg) << (2*H));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_reg   <= t_rh - t_ps;
            da_reg   <= t_fs - t_rh;
            rb_reg   <= t_fh - t_rs;
            db_reg   <= t_rs - t_ph;
            den1_reg <= DW'(SB'(t_rh - t_ps)) + DW'(SB'(t_fs - t_rh))
                      + DW'(SB'(t_fh - t_rs)) + DW'(SB'(t_rs - t_ph));

            pll_reg  <= ra_x[H-1:0] * rb_x[H-1:0];
            plh_reg  <= ra_x[H-1:0] * rb_x[2*H-1:H];
            phl_reg  <= ra_x[2*H-1:H] * rb_x[H-1:0];
            phh_reg  <= ra_x[2*H-1:H] * rb_x[2*H-1:H];
            qll_reg  <= da_x[H-1:0] * db_x[H-1:0];
            qlh_reg  <= da_x[H-1:0] * db_x[2*H-1:H];
            qhl_reg  <= da_x[2*H-1:H] * db_x[H-1:0];
            qhh_reg  <= da_x[2*H-1:H] * db_x[2*H-1:H];
            den2_reg <= den1_reg;

            p_reg    <= p_next[2*SB-1:0];
            q_reg    <= q_next[2*SB-1:0];
            den3_reg <= den2_reg;

            flags_reg.neg  <= (p_reg < q_reg);
            flags_reg.zero <= (den3_reg == '0);
            mag_reg  <= (p_reg < q_reg) ? (q_reg - p_reg) : (p_reg - q_reg);
            den4_reg <= den3_reg;
        end
    end

    assign mag_valid = v4_reg;
    assign mag       = mag_reg;
    assign den       = den4_reg;
    assign flags     = flags_reg;

endmodule

### rtl/core/dstwr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dstwr_div #(
    parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     num_valid,
    input  logic [2*STAMP_BITS-1:0]  num,
    input  logic [STAMP_BITS+1:0]    den,
    input  dstwr_pkg::flags_t        flags_in,
    output logic                     quo_valid,
    output logic [2*STAMP_BITS-1:0]  quo,
    output dstwr_pkg::flags_t        flags_out
);
    import dstwr_pkg::*;

    localparam int NW = 2 * STAMP_BITS;
    localparam int DW = STAMP_BITS + 2;

    logic          v_reg   [NW];
    logic [NW-1:0] n_reg   [NW];
    logic [NW-1:0] q_reg   [NW];
    logic [DW:0]   rem_reg [NW];
    logic [DW-1:0] den_reg [NW];
    flags_t        f_reg   [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic          v_in;
            logic [NW-1:0] n_in, q_in;
            logic [DW:0]   rem_in, rem_sh;
            logic [DW-1:0] den_in;
            flags_t        f_in;
            logic          take;

            if (k == 0)
            begin : g_first
                assign v_in   = num_valid;
                assign n_in   = num;
                assign q_in   = '0;
                assign rem_in = '0;
                assign den_in = den;
                assign f_in   = flags_in;
            end
            else
            begin : g_next
                assign v_in   = v_reg[k-1];
                assign n_in   = n_reg[k-1];
                assign q_in   = q_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign f_in   = f_reg[k-1];
            end

            // remainder stays below den, so the shifted value fits DW+1 bits
            assign rem_sh = {rem_in[DW-1:0], n_in[NW-1]};
            assign take   = (rem_sh >= {1'b0, den_in});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (adv)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    n_reg[k]   <= {n_in[NW-2:0], 1'b0};
                    q_reg[k]   <= {q_in[NW-2:0], take};
                    rem_reg[k] <= take ? (rem_sh - {1'b0, den_in}) : rem_sh;
                    den_reg[k] <= den_in;
                    f_reg[k]   <= f_in;
                end
            end
        end
    endgenerate

    assign quo_valid = v_reg[NW-1];
    assign quo       = q_reg[NW-1];
    assign flags_out = f_reg[NW-1];

endmodule

### rtl/core/dstwr_scale.sv
// Range checks, millimetre scaling and output register.
module dstwr_scale #(
    parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       quo_valid,
    input  logic [2*STAMP_BITS-1:0]    quo,
    input  dstwr_pkg::flags_t          flags,
    input  logic [dstwr_pkg::MM_BITS-1:0] mm_per_tick,
    output logic                       res_valid,
    output dstwr_pkg::out_t            res
);
    import dstwr_pkg::*;

    localparam int NW = 2 * STAMP_BITS;
    localparam int QW = (NW > 33) ? NW : 33;
    localparam int PRW = 32 + MM_BITS;

    logic [QW-1:0] quo_x, pos_max, neg_mag;
    logic          sat;

    logic            va_reg;
    logic [32:0]     flight_a_reg;
    logic [1:0]      status_a_reg;
    logic            use_prod_reg;
    logic [PRW-1:0]  prod_reg;

    logic            vb_reg;
    out_t            res_reg;
    out_t            res_next;

    assign quo_x   = QW'(quo);
    assign pos_max = QW'({1'b0, 32'hFFFF_FFFF});
    assign neg_mag = QW'({1'b1, 32'h0000_0000});
    assign sat     = flags.neg ? (quo_x > neg_mag) : (quo_x > pos_max);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= quo_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= quo_x[31:0] * mm_per_tick;
            use_prod_reg <= 1'b0;
            if (flags.zero)
            begin
                flight_a_reg <= '0;
                status_a_reg <= ST_ZERO;
            end
            else if (sat)
            begin
                flight_a_reg <= flags.neg ? {1'b1, 32'h0} : {1'b0, 32'hFFFF_FFFF};
                status_a_reg <= ST_SAT;
            end
            else if (flags.neg && (quo_x != '0))
            begin
                flight_a_reg <= 33'd0 - quo_x[32:0];
                status_a_reg <= ST_NEG;
            end
            else
            begin
                flight_a_reg <= quo_x[32:0];
                status_a_reg <= ST_OK;
                use_prod_reg <= 1'b1;
            end
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        res_next.flight_ticks = flight_a_reg;
        res_next.status       = status_a_reg;
        res_next.distance_mm  = '0;
        if (use_prod_reg)
        begin
            if (prod_reg[PRW-1:48] != '0)
            begin
                res_next.distance_mm = 32'hFFFF_FFFF;
                res_next.status      = ST_SAT;
            end
            else
                res_next.distance_mm = prod_reg[47:16];
        end
        else if (status_a_reg == ST_SAT && !flight_a_reg[32])
            res_next.distance_mm = 32'hFFFF_FFFF;
    end

    assign res_valid = vb_reg;
    assign res       = res_reg;

endmodule

### rtl/core/ds_twr_distance.sv
// Top level of the double-sided two-way ranging distance pipeline.
// The result is registered through the front stages, the one-bit-per-stage divider pipeline
// and the scaling registers.
// Throughput: one exchange per cycle; a stalled output holds the whole pipeline.
// Reset clears all valid bits and loads mm_reg (mm per tick, unsigned Q8.16) with 307386.
module ds_twr_distance #(
    parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dstwr_pkg::in_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dstwr_pkg::out_t                out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dstwr_pkg::MM_BITS-1:0]  cfg_data
);
    import dstwr_pkg::*;

    logic                    adv;
    logic                    mag_valid, quo_valid;
    logic [2*STAMP_BITS-1:0] mag, quo;
    logic [STAMP_BITS+1:0]   den;
    flags_t                  f_front, f_div;
    logic [MM_BITS-1:0]      mm_reg;

    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mm_reg <= MM_RESET;
        else if (cfg_valid)
            mm_reg <= cfg_data;
    end

    dstwr_front #(.STAMP_BITS(STAMP_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .mag_valid (mag_valid),
        .mag       (mag),
        .den       (den),
        .flags     (f_front)
    );

    dstwr_div #(.STAMP_BITS(STAMP_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .num_valid (mag_valid),
        .num       (mag),
        .den       (den),
        .flags_in  (f_front),
        .quo_valid (quo_valid),
        .quo       (quo),
        .flags_out (f_div)
    );

    dstwr_scale #(.STAMP_BITS(STAMP_BITS)) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .quo_valid   (quo_valid),
        .quo         (quo),
        .flags       (f_div),
        .mm_per_tick (mm_reg),
        .res_valid   (out_valid),
        .res         (out_data)
    );

endmodule
